@@ rtl/grr_pkg.sv @@
package grr_pkg;

  localparam int GLYPH_WORDS_DEF = 4096;
  localparam int CHAR_SLOTS_DEF = 256;
  localparam int MAX_GLYPH_WIDTH = 32;
  localparam int MAX_GLYPH_HEIGHT = 32;

  localparam int WCAP = (MAX_GLYPH_WIDTH < 32) ? MAX_GLYPH_WIDTH : 32;
  localparam int HCAP = (MAX_GLYPH_HEIGHT < 32) ? MAX_GLYPH_HEIGHT : 32;
  localparam logic [5:0] WCAP6 = 6'(WCAP);
  localparam logic [5:0] HCAP6 = 6'(HCAP);

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 11;
  localparam int IDX_W = 8;

  typedef enum logic [1:0] {
    OP_LOAD_GLYPH  = 2'd0,
    OP_LOAD_WIDTH  = 2'd1,
    OP_LOAD_OFFSET = 2'd2,
    OP_DRAW        = 2'd3
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FONT_HEIGHT      = 3'd0,
    REG_FONT_MAX_WIDTH   = 3'd1,
    REG_FIRST_CHAR       = 3'd2,
    REG_CHAR_COUNT       = 3'd3,
    REG_USE_WIDTH_TABLE  = 3'd4,
    REG_USE_OFFSET_TABLE = 3'd5,
    REG_SCREEN_WIDTH     = 3'd6,
    REG_SCREEN_HEIGHT    = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SETUP,
    S_ADDR,
    S_FETCH,
    S_W1,
    S_W2,
    S_ZERO
  } state_t;

  typedef struct packed {
    logic [5:0]  font_height;
    logic [5:0]  font_max_width;
    logic [7:0]  first_char;
    logic [8:0]  char_count;
    logic        use_width_table;
    logic        use_offset_table;
    logic [10:0] screen_width;
    logic [10:0] screen_height;
  } cfg_t;

endpackage

@@ rtl/grr_glyph_ram.sv @@
module grr_glyph_ram import grr_pkg::*; #(
  parameter int GLYPH_WORDS = GLYPH_WORDS_DEF,
  localparam int AW = $clog2(GLYPH_WORDS)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data
);

  logic [15:0] mem [GLYPH_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/grr_char_tab.sv @@
module grr_char_tab import grr_pkg::*; #(
  parameter int CHAR_SLOTS = CHAR_SLOTS_DEF,
  localparam int CW = (CHAR_SLOTS > 1) ? $clog2(CHAR_SLOTS) : 1
) (
  input  logic          clk,
  input  logic          width_wr,
  input  logic          offset_wr,
  input  logic [CW-1:0] wr_addr,
  input  logic [5:0]    width_data,
  input  logic [11:0]   offset_data,
  input  logic [CW-1:0] rd_addr,
  output logic [5:0]    width_rd,
  output logic [11:0]   offset_rd
);

  logic [5:0]  width_mem [CHAR_SLOTS];
  logic [11:0] offset_mem [CHAR_SLOTS];

  always_ff @(posedge clk) begin
    if (width_wr) begin
      width_mem[wr_addr] <= width_data;
    end
    if (offset_wr) begin
      offset_mem[wr_addr] <= offset_data;
    end
    width_rd <= width_mem[rd_addr];
    offset_rd <= offset_mem[rd_addr];
  end

endmodule

@@ rtl/grr_engine.sv @@
module grr_engine import grr_pkg::*; #(
  parameter int GLYPH_WORDS = GLYPH_WORDS_DEF,
  parameter int CHAR_SLOTS = CHAR_SLOTS_DEF,
  localparam int AW = $clog2(GLYPH_WORDS),
  localparam int CW = (CHAR_SLOTS > 1) ? $clog2(CHAR_SLOTS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [11:0]        table_index,
  input  logic [15:0]        table_value,
  input  logic signed [10:0] pos_x,
  input  logic signed [10:0] pos_y,
  input  logic [7:0]         char_code,
  input  logic [15:0]        color,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [11:0] row_y,
  output logic signed [10:0] start_x,
  output logic [31:0]        pixel_mask,
  output logic [15:0]        pixel_color,
  output logic [5:0]         char_width,
  output logic               last_row,
  output logic               gw_en,
  output logic [AW-1:0]      gw_addr,
  output logic [15:0]        gw_data,
  output logic               gr_en,
  output logic [AW-1:0]      gr_addr,
  input  logic [15:0]        gr_data,
  output logic               tw_width,
  output logic               tw_offset,
  output logic [CW-1:0]      t_waddr,
  output logic [5:0]         t_width_data,
  output logic [11:0]        t_offset_data,
  output logic [CW-1:0]      t_raddr,
  input  logic [5:0]         t_width_rd,
  input  logic [11:0]        t_offset_rd
);

  localparam logic [8:0] SLOTS9 = 9'(CHAR_SLOTS);

  state_t state, state_next;

  logic [10:0]      px;
  logic [10:0]      py;
  logic [15:0]      col;
  logic [IDX_W-1:0] idx;
  logic [5:0]       w;
  logic [5:0]       h;
  logic [5:0]       row;
  logic [AW-1:0]    addr;
  logic [15:0]      word0;
  logic [31:0]      colmask;

  op_t         op;
  logic        in_fire;
  logic        slot_free;
  logic [8:0]  code_diff;
  logic        reject;
  logic [5:0]  w_sel;
  logic [5:0]  w_sat;
  logic [5:0]  h_sat;
  logic [1:0]  words;
  logic [6:0]  mh;
  logic [14:0] prod;
  logic [31:0] base;
  logic [31:0] tidx32;
  logic [11:0] ry;
  logic        row_vis;
  logic        last;
  logic [15:0] lo_word;
  logic [31:0] glyph32;
  logic [31:0] colmask_new;
  logic [11:0] cx;
  logic        emit;
  logic        emit_zero;
  logic        take_word0;

  assign op = op_t'(operation);
  assign in_fire = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign tidx32 = 32'(table_index);

  assign code_diff = {1'b0, char_code} - {1'b0, cfg.first_char};
  assign reject = (char_code < cfg.first_char) || (code_diff >= cfg.char_count) ||
                  (code_diff >= SLOTS9);

  assign w_sel = cfg.use_width_table ? t_width_rd : cfg.font_max_width;
  assign w_sat = (w_sel > WCAP6) ? WCAP6 : w_sel;
  assign h_sat = (cfg.font_height > HCAP6) ? HCAP6 : cfg.font_height;

  assign words = 2'((7'(w) + 7'd15) >> 4);
  assign mh = (words == 2'd2) ? {h, 1'b0} : ((words == 2'd1) ? {1'b0, h} : 7'd0);
  assign prod = 15'(mh) * 15'(idx);
  assign base = cfg.use_offset_table ? 32'(t_offset_rd) : 32'(prod);

  assign ry = {py[10], py} + {6'd0, row};
  assign row_vis = !ry[11] && (ry[10:0] < cfg.screen_height);
  assign last = (h == 6'd0) || ((7'(row) + 7'd1) == 7'(h));

  assign lo_word = (state == S_W2) ? word0 : gr_data;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      glyph32[i] = lo_word[15-i];
      glyph32[16+i] = gr_data[15-i];
    end
  end

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      cx = {px[10], px} + 12'(i);
      colmask_new[i] = (6'(i) < w) && !cx[11] && (cx[10:0] < cfg.screen_width);
    end
  end

  assign gw_addr = tidx32[AW-1:0];
  assign gw_data = table_value;
  assign t_waddr = tidx32[CW-1:0];
  assign t_width_data = table_value[5:0];
  assign t_offset_data = table_value[11:0];
  assign t_raddr = idx[CW-1:0];
  assign gr_addr = addr;

  always_comb begin
    state_next = state;
    in_ready = (state == S_IDLE);
    gw_en = 1'b0;
    tw_width = 1'b0;
    tw_offset = 1'b0;
    gr_en = 1'b0;
    emit = 1'b0;
    emit_zero = 1'b0;
    take_word0 = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (op)
            OP_LOAD_GLYPH:  gw_en = (tidx32 < 32'(GLYPH_WORDS));
            OP_LOAD_WIDTH:  tw_width = (tidx32 < 32'(CHAR_SLOTS));
            OP_LOAD_OFFSET: tw_offset = (tidx32 < 32'(CHAR_SLOTS));
            OP_DRAW:        state_next = reject ? S_ZERO : S_LOOK;
          endcase
        end
      end
      S_LOOK: state_next = S_SETUP;
      S_SETUP: state_next = S_ADDR;
      S_ADDR: state_next = (w == 6'd0 || h == 6'd0) ? S_ZERO : S_FETCH;
      S_FETCH: begin
        gr_en = 1'b1;
        state_next = S_W1;
      end
      S_W1: begin
        if (words == 2'd2) begin
          take_word0 = 1'b1;
          gr_en = 1'b1;
          state_next = S_W2;
        end else if (slot_free) begin
          emit = 1'b1;
          gr_en = !last;
          state_next = last ? S_IDLE : S_W1;
        end
      end
      S_W2: begin
        if (slot_free) begin
          emit = 1'b1;
          gr_en = !last;
          state_next = last ? S_IDLE : S_W1;
        end
      end
      S_ZERO: begin
        if (slot_free) begin
          emit = 1'b1;
          emit_zero = 1'b1;
          state_next = last ? S_IDLE : S_ZERO;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && op == OP_DRAW) begin
      px <= pos_x;
      py <= pos_y;
      col <= color;
      idx <= code_diff[IDX_W-1:0];
      row <= 6'd0;
      w <= 6'd0;
      h <= 6'd0;
    end
    if (state == S_SETUP) begin
      w <= w_sat;
      h <= h_sat;
    end
    if (state == S_ADDR) begin
      addr <= base[AW-1:0];
      colmask <= colmask_new;
    end
    if (gr_en) begin
      addr <= addr + AW'(1);
    end
    if (take_word0) begin
      word0 <= gr_data;
    end
    if (emit) begin
      row_y <= ry;
      start_x <= px;
      pixel_mask <= emit_zero ? 32'd0 : (glyph32 & colmask & {32{row_vis}});
      pixel_color <= col;
      char_width <= w;
      last_row <= last;
      row <= row + 6'd1;
    end
  end

endmodule

@@ rtl/glyph_row_rasterizer.sv @@
// Glyph row rasterizer: load beats (glyph word, width, offset) go to the glyph RAM or the
// character table while idle and produce nothing. A draw beat passes through set-up (table
// read, width and height selection, start-word multiply, first glyph read) and then delivers
// one row beat per cycle, while the consumer takes them, for glyphs up to 16 pixels wide;
// wider glyphs need two words per row, both read through the single read port of the glyph
// RAM before each row beat. A rejected character or a zero-sized glyph gives its rows with an
// empty pixel mask, a rejected character only one. Row beats wait in the output register while
// the consumer stalls, and no new beat is taken until the last row of a draw is in that register.
module glyph_row_rasterizer import grr_pkg::*; #(
  parameter int GLYPH_WORDS = GLYPH_WORDS_DEF,
  parameter int CHAR_SLOTS = CHAR_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             operation,
  input  logic [11:0]            table_index,
  input  logic [15:0]            table_value,
  input  logic signed [10:0]     pos_x,
  input  logic signed [10:0]     pos_y,
  input  logic [7:0]             char_code,
  input  logic [15:0]            color,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [11:0]     row_y,
  output logic signed [10:0]     start_x,
  output logic [31:0]            pixel_mask,
  output logic [15:0]            pixel_color,
  output logic [5:0]             char_width,
  output logic                   last_row
);

  localparam int AW = $clog2(GLYPH_WORDS);
  localparam int CW = (CHAR_SLOTS > 1) ? $clog2(CHAR_SLOTS) : 1;

  cfg_t cfg;

  logic          gw_en;
  logic [AW-1:0] gw_addr;
  logic [15:0]   gw_data;
  logic          gr_en;
  logic [AW-1:0] gr_addr;
  logic [15:0]   gr_data;
  logic          tw_width;
  logic          tw_offset;
  logic [CW-1:0] t_waddr;
  logic [5:0]    t_width_data;
  logic [11:0]   t_offset_data;
  logic [CW-1:0] t_raddr;
  logic [5:0]    t_width_rd;
  logic [11:0]   t_offset_rd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.font_height <= 6'd16;
      cfg.font_max_width <= 6'd8;
      cfg.first_char <= 8'd0;
      cfg.char_count <= 9'd256;
      cfg.use_width_table <= 1'b0;
      cfg.use_offset_table <= 1'b0;
      cfg.screen_width <= 11'd480;
      cfg.screen_height <= 11'd320;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FONT_HEIGHT:      cfg.font_height <= cfg_data[5:0];
        REG_FONT_MAX_WIDTH:   cfg.font_max_width <= cfg_data[5:0];
        REG_FIRST_CHAR:       cfg.first_char <= cfg_data[7:0];
        REG_CHAR_COUNT:       cfg.char_count <= cfg_data[8:0];
        REG_USE_WIDTH_TABLE:  cfg.use_width_table <= cfg_data[0];
        REG_USE_OFFSET_TABLE: cfg.use_offset_table <= cfg_data[0];
        REG_SCREEN_WIDTH:     cfg.screen_width <= cfg_data[10:0];
        REG_SCREEN_HEIGHT:    cfg.screen_height <= cfg_data[10:0];
      endcase
    end
  end

  grr_glyph_ram #(
    .GLYPH_WORDS(GLYPH_WORDS)
  ) u_glyph_ram (
    .clk     (clk),
    .wr_en   (gw_en),
    .wr_addr (gw_addr),
    .wr_data (gw_data),
    .rd_en   (gr_en),
    .rd_addr (gr_addr),
    .rd_data (gr_data)
  );

  grr_char_tab #(
    .CHAR_SLOTS(CHAR_SLOTS)
  ) u_char_tab (
    .clk         (clk),
    .width_wr    (tw_width),
    .offset_wr   (tw_offset),
    .wr_addr     (t_waddr),
    .width_data  (t_width_data),
    .offset_data (t_offset_data),
    .rd_addr     (t_raddr),
    .width_rd    (t_width_rd),
    .offset_rd   (t_offset_rd)
  );

  grr_engine #(
    .GLYPH_WORDS(GLYPH_WORDS),
    .CHAR_SLOTS(CHAR_SLOTS)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .table_index   (table_index),
    .table_value   (table_value),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .char_code     (char_code),
    .color         (color),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .row_y         (row_y),
    .start_x       (start_x),
    .pixel_mask    (pixel_mask),
    .pixel_color   (pixel_color),
    .char_width    (char_width),
    .last_row      (last_row),
    .gw_en         (gw_en),
    .gw_addr       (gw_addr),
    .gw_data       (gw_data),
    .gr_en         (gr_en),
    .gr_addr       (gr_addr),
    .gr_data       (gr_data),
    .tw_width      (tw_width),
    .tw_offset     (tw_offset),
    .t_waddr       (t_waddr),
    .t_width_data  (t_width_data),
    .t_offset_data (t_offset_data),
    .t_raddr       (t_raddr),
    .t_width_rd    (t_width_rd),
    .t_offset_rd   (t_offset_rd)
  );

endmodule
